FILE: src/swma_pkg.sv
// swma_pkg: shared defaults for the sliding window moving average block
// no dependencies; imported by the interfaces and the top level

package swma_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // width that holds a count from 0 up to the given maximum
    function automatic int count_width(input int max_value);
        return $clog2(max_value + 1);
    endfunction

endpackage

FILE: src/swma_ifs.sv
// swma_ifs: valid/ready channel interfaces for the sample and result items
// depends on swma_pkg for default widths

interface swma_sample_if
    import swma_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swma_result_if
    import swma_pkg::*;
#(
    parameter int AVG_BITS  = SAMPLE_BITS_DEF + FRAC_BITS_DEF,
    parameter int FILL_BITS = count_width(WINDOW_MAX_DEF)
);
    logic                       valid;
    logic                       ready;
    logic signed [AVG_BITS-1:0] average;
    logic        [FILL_BITS-1:0] fill_count;

    modport source (output valid, output average, output fill_count, input ready);
    modport sink   (input valid, input average, input fill_count, output ready);
endinterface

FILE: src/sliding_window_moving_average.sv
// sliding_window_moving_average: moving average over a ring of recent samples
// depends on swma_pkg, swma_ifs, swma_ram and swma_div

// Each accepted sample yields one result: the mean of the samples now held in
// the window, as signed fixed point with FRAC_BITS fraction bits truncated
// toward zero, plus the fill count. Samples live in a one-port-read ram; the
// running sum and fill count sit in registers. The block works on one item at
// a time; a bit-serial divider divides the scaled sum by the fill count. A
// new item is accepted while the previous result waits in the output
// register. Writing the window size empties the window; do so only while no
// item is in flight. A size of zero acts as one, a size above WINDOW_MAX acts
// as WINDOW_MAX.

module sliding_window_moving_average
    import swma_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int FILL_W      = count_width(WINDOW_MAX)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [FILL_W-1:0] i_cfg_data,
    swma_sample_if.sink       i_in,
    swma_result_if.source     o_out
);

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W = SAMPLE_BITS + AW + 1;
    localparam int DVD_W = SUM_W + FRAC_BITS;
    localparam int AVG_W = SAMPLE_BITS + FRAC_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_ST   = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [FILL_W-1:0]         r_wsize, n_wsize;
    logic [FILL_W-1:0]         r_ptr, n_ptr;
    logic [FILL_W-1:0]         r_count, n_count;
    logic signed [SUM_W-1:0]   r_sum, n_sum;
    logic signed [SAMPLE_BITS-1:0] r_smp, n_smp;
    logic                      r_full, n_full;
    logic                      r_neg, n_neg;
    logic                      r_out_valid, n_out_valid;
    logic signed [AVG_W-1:0]   r_avg, n_avg;
    logic [FILL_W-1:0]         r_fill, n_fill;
    // divider done is a pulse; remember it until the result can leave
    logic                      r_done_seen, n_done_seen;

    logic [FILL_W-1:0]         win;
    logic [FILL_W-1:0]         slot;
    logic [FILL_W-1:0]         slot_inc;
    logic                      in_acc;
    logic                      out_load;
    logic                      ram_we;
    logic [SAMPLE_BITS-1:0]    ram_rdata;
    logic [SUM_W-1:0]          sum_mag;
    logic                      div_start;
    logic                      div_done;
    logic [DVD_W-1:0]          div_q;
    logic [DVD_W-1:0]          q_signed;

    swma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot[AW-1:0]),
        .i_wdata (r_smp),
        .i_raddr (slot[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    swma_div #(
        .DVD_W (DVD_W),
        .DVS_W (FILL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DVD_W'(sum_mag) << FRAC_BITS),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        // effective window: zero acts as one, large values clamp
        if (r_wsize == '0) begin
            win = FILL_W'(1);
        end else if (r_wsize > FILL_W'(WINDOW_MAX)) begin
            win = FILL_W'(WINDOW_MAX);
        end else begin
            win = r_wsize;
        end
        slot     = (r_ptr >= win) ? '0 : r_ptr;
        slot_inc = slot + 1'b1;

        in_acc    = i_in.valid && (r_state == S_IDLE);
        out_load  = (r_state == S_DIV) && r_done_seen && (!r_out_valid || o_out.ready);
        ram_we    = (r_state == S_RD);
        div_start = (r_state == S_ST);
        sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        q_signed  = r_neg ? (~div_q + 1'b1) : div_q;

        n_state     = r_state;
        n_wsize     = r_wsize;
        n_ptr       = r_ptr;
        n_count     = r_count;
        n_sum       = r_sum;
        n_smp       = r_smp;
        n_full      = r_full;
        n_neg       = r_neg;
        n_avg       = r_avg;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !o_out.ready;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_smp   = i_in.sample;
                    n_full  = (r_count >= win);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // ring data for the current slot is valid now
                n_sum   = r_sum + SUM_W'(r_smp)
                        - (r_full ? SUM_W'($signed(ram_rdata)) : SUM_W'(0));
                n_count = r_full ? win : r_count + 1'b1;
                n_ptr   = (slot_inc >= win) ? '0 : slot_inc;
                n_state = S_ST;
            end
            S_ST: begin
                n_neg   = r_sum[SUM_W-1];
                n_state = S_DIV;
            end
            S_DIV: begin
                // quotient stays in the divider until the output register frees
                if (out_load) begin
                    n_avg       = AVG_W'(q_signed);
                    n_fill      = r_count;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_wsize = i_cfg_data;
            n_ptr   = '0;
            n_count = '0;
            n_sum   = '0;
        end
    end

    always_comb begin
        n_done_seen = r_done_seen;
        if (div_start) begin
            n_done_seen = 1'b0;
        end else if (div_done) begin
            n_done_seen = 1'b1;
        end
        if (out_load) begin
            n_done_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wsize     <= FILL_W'(1);
            r_ptr       <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_done_seen <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wsize     <= n_wsize;
            r_ptr       <= n_ptr;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            r_done_seen <= n_done_seen;
        end
        r_smp  <= n_smp;
        r_full <= n_full;
        r_neg  <= n_neg;
        r_avg  <= n_avg;
        r_fill <= n_fill;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.average    = r_avg;
    assign o_out.fill_count = r_fill;

endmodule

FILE: src/swma_ram.sv
// swma_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module swma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/swma_div.sv
// swma_div: unsigned restoring divider, one quotient bit per cycle
// no dependencies; used by the moving average top level

module swma_div #(
    parameter int DVD_W = 31,
    parameter int DVS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [DVD_W-1:0] r_q, n_q;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_q[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DVD_W);
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the divisor width
            n_rem = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            n_q   = {r_q[DVD_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: verif/tb.sv
// tb: self-checking bench for the sliding window moving average block
// depends on swma_pkg, swma_ifs and sliding_window_moving_average; sends samples,
// predicts each mean and fill count, and checks every result in order
`timescale 1ns / 100ps

module tb;
    import swma_pkg::*;

    localparam int SAMPLE_W      = SAMPLE_BITS_DEF;
    localparam int AVG_W         = SAMPLE_BITS_DEF + FRAC_BITS_DEF;
    localparam int FILL_W        = count_width(WINDOW_MAX_DEF);
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    typedef struct {
        logic signed [AVG_W-1:0] average;
        logic [FILL_W-1:0]       fill_count;
    } mean_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [FILL_W-1:0] i_cfg_data;

    swma_sample_if sample_ch ();
    swma_result_if result_ch ();

    sliding_window_moving_average u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (sample_ch.sink),
        .o_out      (result_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state: copy of the window as the block should hold it
    logic signed [SAMPLE_W-1:0] ring_copy [WINDOW_MAX_DEF];
    int                         wr_slot;
    int                         held_n;
    longint                     window_sum;
    logic [FILL_W-1:0]          size_reg;

    mean_t pending_means[$];

    int  errors       = 0;
    int  samples_sent = 0;
    int  results_seen = 0;
    int  size_writes  = 0;
    bit  tx_gaps_on   = 1'b0;
    bit  rx_stalls_on = 1'b0;
    int  hold_request = 0;
    int  hold_left    = 0;
    int  stall_left   = 0;

    function automatic void empty_window_copy();
        wr_slot    = 0;
        held_n     = 0;
        window_sum = 0;
    endfunction

    // push the new sample into the window copy and queue the mean it yields
    function automatic void advance_window(input logic signed [SAMPLE_W-1:0] s);
        int     w;
        int     slot;
        longint scaled;
        mean_t  m;
        w = int'(size_reg);
        if (w == 0) w = 1;
        if (w > WINDOW_MAX_DEF) w = WINDOW_MAX_DEF;
        slot = wr_slot;
        if (slot >= w) slot = 0;
        if (held_n >= w) begin
            window_sum -= ring_copy[slot];
            held_n = w;
        end else begin
            held_n++;
        end
        ring_copy[slot] = s;
        window_sum += s;
        slot++;
        if (slot >= w) slot = 0;
        wr_slot = slot;
        scaled = window_sum * 64'sd256;
        m.average    = AVG_W'(scaled / longint'(held_n));
        m.fill_count = FILL_W'(held_n);
        pending_means.push_back(m);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return SAMPLE_W'(int'($urandom_range(0, 8)) - 4);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // valid stays high on return so back-to-back items need no second write
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= s;
        do @(posedge i_clk); while (!sample_ch.ready);
        advance_window(s);
        samples_sent++;
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            sample_ch.valid  <= 1'b0;
            sample_ch.sample <= SAMPLE_W'($urandom);
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_means.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [FILL_W-1:0] size);
        sample_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = size;
        empty_window_copy();
        size_writes++;
    endtask

    // result side: ready with random stall bursts and an optional long hold
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left != 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 13);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        mean_t want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_means.size() == 0) begin
                $display("%0t: unexpected result, expected none, got average %0d fill %0d",
                         $time, result_ch.average, result_ch.fill_count);
                errors++;
            end else begin
                want = pending_means.pop_front();
                results_seen++;
                if (result_ch.average !== want.average) begin
                    $display("%0t: average mismatch, expected %0d, got %0d",
                             $time, want.average, result_ch.average);
                    errors++;
                end
                if (result_ch.fill_count !== want.fill_count) begin
                    $display("%0t: fill count mismatch, expected %0d, got %0d",
                             $time, want.fill_count, result_ch.fill_count);
                    errors++;
                end
            end
        end
    end

    // reset size is one, so each mean is the sample itself
    task automatic test_reset_size();
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
    endtask

    // zero acts as one, anything above the ring depth saturates
    task automatic test_size_limits();
        set_window(7'd0);
        send_sample(16'sd1);
        send_sample(16'sd0);
        set_window(7'd127);
        send_sample(16'sh7fff);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        set_window(7'd65);
        send_sample(-16'sd3);
        send_sample(16'sd2);
    endtask

    // small window so the ring wraps and the oldest sample is dropped
    task automatic test_wraparound();
        set_window(7'd3);
        repeat (3) send_sample(16'sh7fff);
        repeat (3) send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd0);
    endtask

    task automatic test_random_windows();
        logic [FILL_W-1:0] sizes [8];
        sizes = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd65, 7'd1, 7'd33, 7'd5};
        sizes[5] = FILL_W'($urandom_range(1, 64));
        sizes[6] = FILL_W'($urandom_range(1, 64));
        sizes[7] = FILL_W'($urandom_range(65, 127));
        foreach (sizes[k]) begin
            tx_gaps_on   = $urandom_range(0, 3) != 0;
            rx_stalls_on = $urandom_range(0, 3) != 0;
            set_window(sizes[k]);
            repeat (45) send_sample(pick_sample());
        end
    endtask

    // output held off long enough that the block backs up and drops input ready
    task automatic test_backpressure();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        set_window(7'd6);
        hold_request = HOLD_CYCLES;
        repeat (12) send_sample(pick_sample());
        sample_ch.valid <= 1'b0;
        wait_drained();
        repeat (8) send_sample(pick_sample());
    endtask

    // no idling from here on; full windows of both extremes
    task automatic test_full_rate();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        set_window(7'd8);
        repeat (10) send_sample(16'sh7fff);
        repeat (10) send_sample(16'sh8000);
        repeat (40) send_sample(pick_sample());
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        size_reg = 7'd1;
        empty_window_copy();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_size();
        test_size_limits();
        test_wraparound();
        test_random_windows();
        test_backpressure();
        test_full_rate();

        sample_ch.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d samples across %0d window size writes, %0d results checked",
                 samples_sent, size_writes, results_seen);
        $display("including zero and oversized windows, ring wrap and a long output hold");
        if (errors == 0 && pending_means.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
